// File: rtl/ksq_pkg.sv
// ----------------------------------------------------------------------------
// ksq_pkg : shared types for the k-th smallest selector
// Transaction payload structs, default sizes and the sequencer state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package ksq_pkg;

	localparam int VALUE_W          = 30;   // width of value / kth_value fields
	localparam int RANK_W           = 10;   // width of rank_k register
	localparam int MAX_ELEMENTS_DEF = 1024;
	localparam int VALUE_BITS_DEF   = 30;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
	} item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] kth_value;
		logic               error;
	} res_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MED_R0,
		ST_MED_R1,
		ST_MED_R2,
		ST_MED_R3,
		ST_MED_CMP,
		ST_MED_W0,
		ST_MED_W1,
		ST_MED_W2,
		ST_P1_RD,
		ST_P1_CHK,
		ST_P2_RD,
		ST_P2_CHK,
		ST_P2_SW,
		ST_P2_LD,
		ST_FX0,
		ST_FX1,
		ST_FIN_RD,
		ST_FIN,
		ST_DONE
	} state_t;

endpackage : ksq_pkg

`default_nettype wire

// File: rtl/ksq_store.sv
// ----------------------------------------------------------------------------
// ksq_store : element store
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ksq_store #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 30,
	parameter int AW    = 10
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule : ksq_store

`default_nettype wire

// File: rtl/kth_smallest_quickselect.sv
// ----------------------------------------------------------------------------
// kth_smallest_quickselect : order statistic selector
// Loads a data set into an on-chip store, then runs an in-place quickselect
// (median-of-three pivot, Lomuto partition) and returns the rank_k-th value.
// ----------------------------------------------------------------------------
//
//  channel | signals                         | direction | payload
//  --------+---------------------------------+-----------+------------------
//  item    | item_valid, item_stall, item    | in        | item_t {value,last}
//  res     | res_valid, res_stall, res       | out       | res_t {kth_value,error}
//  cfg     | cfg_valid, cfg_ready, cfg_data  | in        | rank_k
//
//  Loading takes one cycle per item transaction while item_stall is low. After
//  the last item the sequencer owns the store: each round does median-of-three
//  reads/writes, then scans the elements, with an extra write and reload when
//  an exchange is made, since every element goes through the one read port.
//  item_stall is high from the last item until the result sits in the output
//  register; a waiting result does not block loading of the next data set.
//  arst_n clears all control state; the store itself is never cleared.
//
`default_nettype none

module kth_smallest_quickselect
	import ksq_pkg::*;
#(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
	parameter int VALUE_BITS   = VALUE_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire item_t             item,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output res_t                   res,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [RANK_W-1:0] cfg_data
);

	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam int KW = (CW > RANK_W) ? CW : RANK_W;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_ELEMENTS);

	state_t state_q, state_nx;

	logic [RANK_W-1:0]     rank_q;
	logic [CW-1:0]         count_q;
	logic                  ovf_q;
	logic [AW-1:0]         lo_q, hi_q, sl_q, sh_q;
	logic [CW-1:0]         piv_q;
	logic [VALUE_BITS-1:0] vm_q, vl_q, vh_q, vsl_q;
	logic                  fwd_q;
	logic [VALUE_BITS-1:0] res_val_q;
	logic                  res_err_q;
	logic                  res_valid_q;
	res_t                  res_q;

	// store ports
	logic                  mem_we;
	logic [AW-1:0]         mem_waddr, mem_raddr;
	logic [VALUE_BITS-1:0] mem_wdata, mem_rdata;

	ksq_store #(
		.DEPTH (MAX_ELEMENTS),
		.WIDTH (VALUE_BITS),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// load-side decode
	logic                  item_acc;
	logic                  has_room;
	logic [CW-1:0]         count_nx;
	logic                  set_err;
	logic [VALUE_BITS-1:0] item_v;

	assign item_acc = item_valid && !item_stall;
	assign has_room = (count_q < MAX_C);
	assign count_nx = has_room ? count_q + CW'(1) : count_q;
	assign set_err  = ovf_q || !has_room || (KW'(rank_q) >= KW'(count_nx));
	assign item_v   = VALUE_BITS'(item.value);

	// selection decode
	logic          piv_hit, piv_above;
	logic [AW:0]   mid_sum;
	logic [AW-1:0] mid;
	logic          le_pivot;

	assign piv_hit   = (KW'(piv_q) == KW'(rank_q));
	assign piv_above = (KW'(piv_q) >  KW'(rank_q));
	assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid       = mid_sum[AW:1];
	assign le_pivot  = (mem_rdata <= vh_q);

	// median-of-three network; mid aliases lo when the window is short
	logic                  med_alias;
	logic [VALUE_BITS-1:0] m0, l0, h0, m1, l1, h1, m2, l2, h2, m3, l3, h3;

	always_comb begin
		med_alias = (mid == lo_q);
		m0 = vm_q;
		l0 = vl_q;
		h0 = vh_q;
		if (m0 < l0) begin
			m1 = l0;
			l1 = m0;
		end else begin
			m1 = m0;
			l1 = l0;
		end
		h1 = h0;
		if (h1 < l1) begin
			h2 = l1;
			l2 = h1;
		end else begin
			h2 = h1;
			l2 = l1;
		end
		m2 = med_alias ? l2 : m1;
		if (m2 < h2) begin
			m3 = h2;
			h3 = m2;
		end else begin
			m3 = m2;
			h3 = h2;
		end
		l3 = med_alias ? m3 : l2;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_acc && item.last) begin
					state_nx = set_err ? ST_DONE : ST_CHECK;
				end
			end
			ST_CHECK:   state_nx = piv_hit ? ST_FIN_RD : ST_MED_R0;
			ST_MED_R0:  state_nx = ST_MED_R1;
			ST_MED_R1:  state_nx = ST_MED_R2;
			ST_MED_R2:  state_nx = ST_MED_R3;
			ST_MED_R3:  state_nx = ST_MED_CMP;
			ST_MED_CMP: state_nx = ST_MED_W0;
			ST_MED_W0:  state_nx = ST_MED_W1;
			ST_MED_W1:  state_nx = ST_MED_W2;
			ST_MED_W2:  state_nx = ST_P1_RD;
			ST_P1_RD:   state_nx = (sl_q == hi_q) ? ST_CHECK : ST_P1_CHK;
			ST_P1_CHK:  state_nx = le_pivot ? ST_P1_RD : ST_P2_RD;
			ST_P2_RD:   state_nx = (sh_q == hi_q) ? ST_FX0 : ST_P2_CHK;
			ST_P2_CHK:  state_nx = le_pivot ? ST_P2_SW : ST_P2_RD;
			ST_P2_SW:   state_nx = ST_P2_LD;
			ST_P2_LD:   state_nx = ST_P2_RD;
			ST_FX0:     state_nx = ST_FX1;
			ST_FX1:     state_nx = ST_CHECK;
			ST_FIN_RD:  state_nx = ST_FIN;
			ST_FIN:     state_nx = ST_DONE;
			ST_DONE: begin
				if (!res_valid_q || !res_stall) begin
					state_nx = ST_IDLE;
				end
			end
			default:    state_nx = ST_IDLE;
		endcase
	end

	// store control and handshake outputs
	always_comb begin
		mem_we     = 1'b0;
		mem_waddr  = count_q[AW-1:0];
		mem_wdata  = item_v;
		mem_raddr  = sl_q;
		item_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE:   mem_we = item_acc && has_room;
			ST_MED_R0: mem_raddr = mid;
			ST_MED_R1: mem_raddr = lo_q;
			ST_MED_R2: mem_raddr = hi_q;
			ST_MED_W0: begin
				mem_we    = 1'b1;
				mem_waddr = mid;
				mem_wdata = vm_q;
			end
			ST_MED_W1: begin
				mem_we    = 1'b1;
				mem_waddr = lo_q;
				mem_wdata = vl_q;
			end
			ST_MED_W2: begin
				mem_we    = 1'b1;
				mem_waddr = hi_q;
				mem_wdata = vh_q;
			end
			ST_P1_RD:  mem_raddr = sl_q;
			ST_P2_RD:  mem_raddr = sh_q;
			ST_P2_CHK: begin
				mem_we    = le_pivot;
				mem_waddr = sl_q;
				mem_wdata = mem_rdata;
			end
			ST_P2_SW: begin
				mem_we    = 1'b1;
				mem_waddr = sh_q;
				mem_wdata = vsl_q;
				mem_raddr = sl_q + AW'(1);
			end
			ST_FX0: begin
				mem_we    = 1'b1;
				mem_waddr = sl_q;
				mem_wdata = vh_q;
			end
			ST_FX1: begin
				mem_we    = 1'b1;
				mem_waddr = hi_q;
				mem_wdata = vsl_q;
			end
			ST_FIN_RD: mem_raddr = piv_q[AW-1:0];
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rank_q      <= '0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid && cfg_ready) begin
				rank_q <= cfg_data;
			end
			if (item_acc) begin
				if (item.last) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
				end else begin
					count_q <= count_nx;
					ovf_q   <= ovf_q || !has_room;
				end
			end
			if (state_q == ST_DONE && (!res_valid_q || !res_stall)) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				// first window spans the whole set: low bound from zero,
				// high bound set by the first check
				lo_q      <= '0;
				piv_q     <= count_nx;
				res_val_q <= '0;
				res_err_q <= set_err;
			end
			ST_CHECK: begin
				if (piv_above) begin
					hi_q <= AW'(piv_q - CW'(1));
				end else begin
					lo_q <= AW'(piv_q + CW'(1));
				end
			end
			ST_MED_R1:  vm_q <= mem_rdata;
			ST_MED_R2:  vl_q <= mem_rdata;
			ST_MED_R3:  vh_q <= mem_rdata;
			ST_MED_CMP: begin
				vm_q <= m3;
				vl_q <= l3;
				vh_q <= h3;
			end
			ST_MED_W2:  sl_q <= lo_q;
			ST_P1_RD: begin
				if (sl_q == hi_q) begin
					piv_q <= CW'(hi_q);
				end
			end
			ST_P1_CHK: begin
				if (le_pivot) begin
					sl_q <= sl_q + AW'(1);
				end else begin
					vsl_q <= mem_rdata;
					sh_q  <= sl_q + AW'(1);
				end
			end
			ST_P2_CHK: begin
				if (!le_pivot) begin
					sh_q <= sh_q + AW'(1);
				end
			end
			ST_P2_SW: begin
				// new low slot is the just-written entry when it meets the scan
				fwd_q <= ((sl_q + AW'(1)) == sh_q);
				sl_q  <= sl_q + AW'(1);
				sh_q  <= sh_q + AW'(1);
			end
			ST_P2_LD: begin
				if (!fwd_q) begin
					vsl_q <= mem_rdata;
				end
			end
			ST_FX1:     piv_q <= CW'(sl_q);
			ST_FIN:     res_val_q <= mem_rdata;
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!res_valid_q || !res_stall)) begin
			res_q.kth_value <= VALUE_W'(res_val_q);
			res_q.error     <= res_err_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign cfg_ready = 1'b1;

endmodule : kth_smallest_quickselect

`default_nettype wire
